[sv/rcft_pkg.sv]
// Shared types, constants and register codes for the raised-cosine fade table.
// Depends on nothing; every other file of the block imports it.
package rcft_pkg;

  localparam int RCFT_TABLE_SIZE = 1024;

  // Input function codes.
  localparam logic [1:0] FUNC_LK_REC  = 2'd0;
  localparam logic [1:0] FUNC_LK_PRE  = 2'd1;
  localparam logic [1:0] FUNC_REBUILD = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_REC_DELAY_RATIO  = 2'd0;
  localparam logic [1:0] REG_PRE_WINDOW_RATIO = 2'd1;
  localparam logic [1:0] REG_REC_DELAY_MIN    = 2'd2;
  localparam logic [1:0] REG_PRE_WINDOW_MIN   = 2'd3;

  localparam logic [15:0] FULL_SCALE = 16'd32768;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

  // Q30 coefficients of the sine polynomial, highest order first.
  localparam logic [31:0] SIN_C9 = 32'd172272;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C1 = 32'd1686629713;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] position;
  } in_item_t;

  typedef struct packed {
    logic [15:0] curve_value;
    logic        rebuilt;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LK_REC,
    OP_LK_PRE,
    OP_REBUILD,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] position;
  } job_t;

  typedef struct packed {
    logic [15:0] rec_delay_ratio;
    logic [15:0] pre_window_ratio;
    logic [9:0]  rec_delay_min;
    logic [10:0] pre_window_min;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LK_READ,
    B_LK_MUL,
    B_OUT,
    B_REC_START,
    B_REC_DIV,
    B_REC_ENTRY,
    B_REC_SIN,
    B_PRE_START,
    B_PRE_DIV,
    B_PRE_ENTRY,
    B_PRE_SIN
  } back_state_t;

endpackage

[sv/rcft_front.sv]
// Front end: a two-entry queue that takes input items and tags each with its operation.
// Depends on rcft_pkg.
module rcft_front
  import rcft_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_take
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_take;
  job_t       job_in;

  always_comb begin
    job_in.position = in_item.position;
    case (in_item.func)
      FUNC_LK_REC:  job_in.op = OP_LK_REC;
      FUNC_LK_PRE:  job_in.op = OP_LK_PRE;
      FUNC_REBUILD: job_in.op = OP_REBUILD;
      default:      job_in.op = OP_NONE;
    endcase
  end

  assign full      = count_r == 2'd2;
  assign job_valid = count_r != 2'd0;
  assign job       = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_take   = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_take) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_take);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= job_in;
  end

endmodule

[sv/rcft_div.sv]
// Restoring divider that forms 2^30 / divisor one quotient bit per cycle.
// Depends on rcft_pkg; used by the back end to set up the curve step.
module rcft_div
  import rcft_pkg::*;
#(
  parameter int TABLE_SIZE = RCFT_TABLE_SIZE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [$clog2(TABLE_SIZE):0]     divisor,
  output logic                            done,
  output logic [30:0]                     quot,
  output logic [$clog2(TABLE_SIZE):0]     rem
);

  localparam int DW = $clog2(TABLE_SIZE) + 1;

  logic          busy_r, done_r;
  logic [4:0]    cnt_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [30:0]   quot_r;
  logic [DW:0]   rem_sh;
  logic          qbit;

  always_comb begin
    // The dividend is 2^30: only its top bit is set.
    rem_sh = {rem_r, cnt_r == 5'd30};
    qbit   = rem_sh >= {1'b0, divisor};
    if (qbit) rem_nxt = DW'(rem_sh - {1'b0, divisor});
    else      rem_nxt = DW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd30;
      end else if (busy_r) begin
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[29:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

[sv/rcft_sin.sv]
// Sequenced raised-cosine unit: sin^2(t*pi/2) in Q1.15 from t in Q1.30.
// Depends on rcft_pkg; one shared multiplier walks the Horner steps.
module rcft_sin
  import rcft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] t,
  output logic        done,
  output logic [15:0] q
);

  logic        busy_r, done_r;
  logic [2:0]  step_r;
  logic [31:0] t_r, t2_r, r_r;
  logic [15:0] q_r, q_nxt;
  logic [31:0] op_a, op_b, coef, sh;
  logic [63:0] prod;
  logic [32:0] rnd_sum;
  logic [17:0] rnd;

  always_comb begin
    op_a = r_r;
    op_b = r_r;
    coef = SIN_C1;
    case (step_r)
      3'd0: begin
        op_a = t_r;
        op_b = t_r;
      end
      3'd1: begin
        op_a = t2_r;
        op_b = SIN_C9;
        coef = SIN_C7;
      end
      3'd2: begin
        op_a = t2_r;
        coef = SIN_C5;
      end
      3'd3: begin
        op_a = t2_r;
        coef = SIN_C3;
      end
      3'd4: begin
        op_a = t2_r;
        coef = SIN_C1;
      end
      3'd5: begin
        op_a = t_r;
      end
      default: begin
        op_a = r_r;
      end
    endcase
    prod    = 64'(op_a) * 64'(op_b);
    sh      = prod[61:30];
    rnd_sum = 33'(sh) + 33'd16384;
    rnd     = rnd_sum[32:15];
    if (rnd > 18'(FULL_SCALE)) q_nxt = FULL_SCALE;
    else                       q_nxt = rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        if (step_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (t > Q30_ONE) t_r <= 32'(Q30_ONE);
      else             t_r <= 32'(t);
    end else if (busy_r) begin
      case (step_r)
        3'd0:    t2_r <= sh;
        3'd1,
        3'd2,
        3'd3,
        3'd4:    r_r  <= coef - sh;
        3'd5:    r_r  <= sh;
        default: q_r  <= q_nxt;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

[sv/rcft_back.sv]
// Back end: both curve tables, the rebuild sequencer, lookup interpolation and result slot.
// Depends on rcft_pkg, rcft_div and rcft_sin.
module rcft_back
  import rcft_pkg::*;
#(
  parameter int TABLE_SIZE = RCFT_TABLE_SIZE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_take,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = IW + 1;
  localparam int PW = 16 + IW;
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

  back_state_t state_r, state_nxt;
  logic [IW-1:0] addr_r, addr_nxt;
  logic [30:0]   t_r, t_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   f_r, f_nxt;
  logic          sel_pre_r, sel_pre_nxt;
  logic [15:0]   val_r, val_nxt;
  logic          rebuilt_r, rebuilt_nxt;
  logic          res_valid_r;
  out_item_t     res_r;
  logic          res_load;

  logic [15:0] rec_mem [TABLE_SIZE];
  logic [15:0] pre_mem [TABLE_SIZE];
  logic [15:0] rec_a_r, rec_b_r, pre_a_r, pre_b_r;
  logic        we_rec, we_pre;
  logic [15:0] wdata;

  logic          div_start, div_done;
  logic [CW-1:0] divisor;
  logic [30:0]   div_quot;
  logic [CW-1:0] div_rem;
  logic          sin_start, sin_done;
  logic [15:0]   sin_q;

  logic [31:0]   ndr_sc, nwp_sc, ndr_w, nwp_w;
  logic [CW-1:0] ndr, nr, nwp;
  logic [PW-1:0] p;
  logic [CW:0]   rsum;
  logic [30:0]   t_rec, t_pre;
  logic [CW-1:0] rem_rec, rem_pre;
  logic [15:0]   tap_a, tap_b;
  logic [16:0]   w_a;
  logic [33:0]   mix;

  // Delay and window lengths, clamped so both curves keep at least one shaped entry.
  always_comb begin
    ndr_sc = (32'(cfg.rec_delay_ratio) * 32'(TABLE_SIZE)) >> 16;
    nwp_sc = (32'(cfg.pre_window_ratio) * 32'(TABLE_SIZE)) >> 16;
    ndr_w  = (ndr_sc < 32'(cfg.rec_delay_min)) ? 32'(cfg.rec_delay_min) : ndr_sc;
    if (ndr_w > 32'(TABLE_SIZE - 2)) ndr_w = 32'(TABLE_SIZE - 2);
    nwp_w  = (nwp_sc < 32'(cfg.pre_window_min)) ? 32'(cfg.pre_window_min) : nwp_sc;
    if (nwp_w < 32'd1) nwp_w = 32'd1;
    if (nwp_w > 32'(TABLE_SIZE)) nwp_w = 32'(TABLE_SIZE);
    ndr = CW'(ndr_w);
    nr  = CW'(TABLE_SIZE - 1) - ndr;
    nwp = CW'(nwp_w);
  end

  // Curve argument steps by the quotient and remainder of 2^30 over the ramp length.
  always_comb begin
    rsum = {1'b0, rem_r} + {1'b0, div_rem};
    if (rsum >= {1'b0, nr}) begin
      rem_rec = CW'(rsum - {1'b0, nr});
      t_rec   = t_r + div_quot + 31'd1;
    end else begin
      rem_rec = CW'(rsum);
      t_rec   = t_r + div_quot;
    end
    if (rem_r < div_rem) begin
      rem_pre = rem_r + nwp - div_rem;
      t_pre   = t_r - div_quot - 31'd1;
    end else begin
      rem_pre = rem_r - div_rem;
      t_pre   = t_r - div_quot;
    end
  end

  always_comb begin
    p     = PW'(job.position) * PW'(TABLE_SIZE - 1);
    tap_a = sel_pre_r ? pre_a_r : rec_a_r;
    tap_b = sel_pre_r ? pre_b_r : rec_b_r;
    w_a   = 17'h10000 - 17'(f_r);
    mix   = 34'(tap_a) * 34'(w_a) + 34'(tap_b) * 34'(f_r) + 34'd32768;
  end

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    t_nxt       = t_r;
    rem_nxt     = rem_r;
    idx_nxt     = idx_r;
    f_nxt       = f_r;
    sel_pre_nxt = sel_pre_r;
    val_nxt     = val_r;
    rebuilt_nxt = rebuilt_r;
    job_take    = 1'b0;
    res_load    = 1'b0;
    we_rec      = 1'b0;
    we_pre      = 1'b0;
    wdata       = '0;
    div_start   = 1'b0;
    divisor     = nr;
    sin_start   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_take    = 1'b1;
          idx_nxt     = p[PW-1:16];
          f_nxt       = p[15:0];
          sel_pre_nxt = job.op == OP_LK_PRE;
          case (job.op)
            OP_LK_REC, OP_LK_PRE: state_nxt = B_LK_READ;
            OP_REBUILD:           state_nxt = B_REC_START;
            default: begin
              val_nxt     = '0;
              rebuilt_nxt = 1'b0;
              state_nxt   = B_OUT;
            end
          endcase
        end
      end
      B_LK_READ: state_nxt = B_LK_MUL;
      B_LK_MUL: begin
        val_nxt     = mix[31:16];
        rebuilt_nxt = 1'b0;
        state_nxt   = B_OUT;
      end
      B_OUT: begin
        if (!res_valid_r || pop) begin
          res_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_REC_START: begin
        div_start = 1'b1;
        state_nxt = B_REC_DIV;
      end
      B_REC_DIV: begin
        if (div_done) begin
          addr_nxt  = '0;
          t_nxt     = '0;
          rem_nxt   = '0;
          state_nxt = B_REC_ENTRY;
        end
      end
      B_REC_ENTRY: begin
        if (addr_r == LAST) begin
          we_rec    = 1'b1;
          wdata     = FULL_SCALE;
          state_nxt = B_PRE_START;
        end else if ({1'b0, addr_r} < ndr) begin
          we_rec   = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else begin
          sin_start = 1'b1;
          state_nxt = B_REC_SIN;
        end
      end
      B_REC_SIN: begin
        if (sin_done) begin
          we_rec    = 1'b1;
          wdata     = sin_q;
          addr_nxt  = addr_r + 1'b1;
          t_nxt     = t_rec;
          rem_nxt   = rem_rec;
          state_nxt = B_REC_ENTRY;
        end
      end
      B_PRE_START: begin
        div_start = 1'b1;
        divisor   = nwp;
        state_nxt = B_PRE_DIV;
      end
      B_PRE_DIV: begin
        divisor = nwp;
        if (div_done) begin
          addr_nxt  = '0;
          t_nxt     = Q30_ONE;
          rem_nxt   = '0;
          state_nxt = B_PRE_ENTRY;
        end
      end
      B_PRE_ENTRY: begin
        divisor = nwp;
        if ({1'b0, addr_r} < nwp) begin
          sin_start = 1'b1;
          state_nxt = B_PRE_SIN;
        end else begin
          we_pre = 1'b1;
          if (addr_r == LAST) begin
            val_nxt     = '0;
            rebuilt_nxt = 1'b1;
            state_nxt   = B_OUT;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
      end
      B_PRE_SIN: begin
        divisor = nwp;
        if (sin_done) begin
          we_pre  = 1'b1;
          wdata   = sin_q;
          t_nxt   = t_pre;
          rem_nxt = rem_pre;
          if (addr_r == LAST) begin
            val_nxt     = '0;
            rebuilt_nxt = 1'b1;
            state_nxt   = B_OUT;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            state_nxt = B_PRE_ENTRY;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load)                 res_valid_r <= 1'b1;
      else if (pop && res_valid_r)  res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    t_r       <= t_nxt;
    rem_r     <= rem_nxt;
    idx_r     <= idx_nxt;
    f_r       <= f_nxt;
    sel_pre_r <= sel_pre_nxt;
    val_r     <= val_nxt;
    rebuilt_r <= rebuilt_nxt;
    if (res_load) begin
      res_r.curve_value <= val_r;
      res_r.rebuilt     <= rebuilt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_rec) rec_mem[addr_r] <= wdata;
    rec_a_r <= rec_mem[idx_r];
    rec_b_r <= rec_mem[idx_r + 1'b1];
  end

  always_ff @(posedge clk) begin
    if (we_pre) pre_mem[addr_r] <= wdata;
    pre_a_r <= pre_mem[idx_r];
    pre_b_r <= pre_mem[idx_r + 1'b1];
  end

  rcft_div #(.TABLE_SIZE(TABLE_SIZE)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (divisor),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  rcft_sin u_sin (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sin_start),
    .t     (t_r),
    .done  (sin_done),
    .q     (sin_q)
  );

  assign empty    = !res_valid_r;
  assign out_item = res_r;

`ifndef SYNTHESIS
  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!res_valid_r || pop))
    else $error("result loaded into an occupied slot");

  a_sin_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sin_done |-> (state_r == B_REC_SIN || state_r == B_PRE_SIN))
    else $error("curve unit finished outside a table write step");

  a_lookup_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_LK_MUL |=> val_r <= FULL_SCALE)
    else $error("interpolated value above full scale");

  a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> (state_r == B_IDLE && job_valid))
    else $error("item taken from the queue while busy");
`endif

endmodule

[sv/raised_cosine_fade_table.sv]
// Raised-cosine fade table: top level with configuration registers, front queue and back end.
// Depends on rcft_pkg, rcft_front and rcft_back.
//
// Use: both channels behave as queues. An item transfers in when push is high and full is
// low; a result transfers out when pop is high and empty is low. Every item gives exactly
// one result, in order. func 0 and 1 look up the record or pre curve at a Q0.16 position
// with linear interpolation; func 2 rebuilds both tables from the registers and answers
// with rebuilt set; func 3 answers with zeros.
// A lookup runs through four steps (address, table read, interpolate, result slot) one
// after another in the back end, so a new lookup is taken only once the last one has
// loaded its result slot.
// A rebuild walks every entry of both tables: shaped entries go through the shared sine
// sequencer, flat entries are written directly, and each curve first needs a division.
// The front queue holds two items, so input keeps flowing while a result waits to be
// popped; a stalled receiver then backs up into full. Reset clears the control state and
// the registers, but sets pre_window_min to 1; the tables hold nothing meaningful until the
// first rebuild. The user must write registers over the APB port only while idle; unchecked.
module raised_cosine_fade_table
  import rcft_pkg::*;
#(
  parameter int TABLE_SIZE = RCFT_TABLE_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  in_item_t    in_item,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       cfg_write;
  logic [1:0] reg_idx;
  logic       job_valid, job_take;
  job_t       job;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rec_delay_ratio  <= '0;
      cfg_r.pre_window_ratio <= '0;
      cfg_r.rec_delay_min    <= '0;
      cfg_r.pre_window_min   <= 11'd1;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_REC_DELAY_RATIO:  cfg_r.rec_delay_ratio  <= pwdata[15:0];
        REG_PRE_WINDOW_RATIO: cfg_r.pre_window_ratio <= pwdata[15:0];
        REG_REC_DELAY_MIN:    cfg_r.rec_delay_min    <= pwdata[9:0];
        REG_PRE_WINDOW_MIN:   cfg_r.pre_window_min   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REC_DELAY_RATIO:  prdata = 32'(cfg_r.rec_delay_ratio);
      REG_PRE_WINDOW_RATIO: prdata = 32'(cfg_r.pre_window_ratio);
      REG_REC_DELAY_MIN:    prdata = 32'(cfg_r.rec_delay_min);
      REG_PRE_WINDOW_MIN:   prdata = 32'(cfg_r.pre_window_min);
      default:              prdata = '0;
    endcase
  end

  rcft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  rcft_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule
